@@ hdl/lfrs_pkg.sv @@
package lfrs_pkg;

  localparam int MAX_CUSTOMERS = 256;
  localparam int MAX_ROUTES    = 16;

  localparam int ROW_LEN   = MAX_CUSTOMERS + 1;
  localparam int TAB_DEPTH = (MAX_ROUTES + 1) * ROW_LEN;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam int POS_W     = $clog2(MAX_CUSTOMERS + 1);
  localparam int STORE_AW  = (MAX_CUSTOMERS > 1) ? $clog2(MAX_CUSTOMERS) : 1;
  localparam int ROUTE_W   = $clog2(MAX_ROUTES + 1);

  localparam int COST_W  = 48;
  localparam int LOAD_W  = 16 + POS_W;
  localparam int SUM_W   = 24 + POS_W + 1;
  localparam int T_W     = SUM_W + 1;
  localparam int CPROD_W = 20 + LOAD_W;
  localparam int DPROD_W = 20 + T_W;
  localparam int RC_W    = DPROD_W + 2;

  localparam logic [COST_W-1:0] COST_UNREACH = {COST_W{1'b1}};
  localparam logic [COST_W-1:0] COST_SAT     = {{(COST_W-1){1'b1}}, 1'b0};

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_PEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_PEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_ON    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLEET     = 3'd5;

  typedef struct packed {
    logic clr;
    logic add;
    logic back;
    logic mul;
    logic sum;
  } cost_cmd_t;

  typedef struct packed {
    logic [15:0] capacity;
    logic [23:0] dur_limit;
    logic [19:0] cap_pen;
    logic [19:0] dur_pen;
    logic        dur_on;
  } cost_cfg_t;

endpackage

@@ hdl/lfrs_cost_unit.sv @@
module lfrs_cost_unit (
  input  logic                      clk,
  input  lfrs_pkg::cost_cmd_t       cmd,
  input  lfrs_pkg::cost_cfg_t       cfg,
  input  logic [15:0]               demand,
  input  logic [23:0]               service_time,
  input  logic [23:0]               leg,
  input  logic [23:0]               to_depot,
  output logic [lfrs_pkg::COST_W-1:0] route_cost,
  output logic                      cut
);
  import lfrs_pkg::*;

  logic [LOAD_W-1:0]  load;
  logic [SUM_W-1:0]   serv;
  logic [SUM_W-1:0]   travel;
  logic [SUM_W-1:0]   back;
  logic [T_W-1:0]     dur;
  logic [CPROD_W-1:0] cprod;
  logic [DPROD_W-1:0] dprod;
  logic [LOAD_W-1:0]  cexc;
  logic [T_W-1:0]     dexc;
  logic [RC_W-1:0]    rc_sum;

  // Limit excesses (else zero), cost sum, cutoff
  always_comb begin
    cexc = (load > LOAD_W'(cfg.capacity)) ? load - LOAD_W'(cfg.capacity) : '0;
    dexc = (cfg.dur_on && dur > T_W'(cfg.dur_limit)) ? dur - T_W'(cfg.dur_limit) : '0;
    rc_sum = RC_W'({back, 8'd0}) + RC_W'(cprod) + RC_W'(dprod);
    cut = cfg.dur_on && (({1'b0, load, 1'b0}) > (LOAD_W + 2)'(3 * {2'b0, cfg.capacity}));
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      load   <= '0;
      serv   <= '0;
      travel <= '0;
    end else if (cmd.add) begin
      load   <= load + LOAD_W'(demand);
      serv   <= serv + SUM_W'(service_time);
      travel <= travel + SUM_W'(leg);
    end
    if (cmd.back) begin
      back <= travel + SUM_W'(to_depot);
      dur  <= T_W'(travel) + T_W'(to_depot) + T_W'(serv);
    end
    if (cmd.mul) begin
      cprod <= CPROD_W'(cfg.cap_pen) * CPROD_W'(cexc);
      dprod <= DPROD_W'(cfg.dur_pen) * DPROD_W'(dexc);
    end
    if (cmd.sum) begin
      route_cost <= (rc_sum > RC_W'(COST_SAT)) ? COST_SAT : rc_sum[COST_W-1:0];
    end
  end

endmodule

@@ hdl/limited_fleet_route_split.sv @@
// Steps: clear table rows 0..fleet over positions 0..n; for each row, read the path
//   cost of each start (PRD, PCHK) and try each (start, end) pair of the dynamic program
//   (JRD to JCMP); then scan route counts and emit route words when the receiver takes them.
// Throughput: one customer word per cycle while loading; in_stall stays high from the
//   last word until the final result word (route or no-solution) is loaded into the output register.
// Reset: synchronous, active high; clears sequencer, customer count and output valid
//   and loads configuration defaults. Customer stores and tables are not cleared.
module limited_fleet_route_split (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [lfrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] demand,
  input  logic [23:0] service_time,
  input  logic [23:0] from_depot,
  input  logic [23:0] to_depot,
  input  logic [23:0] to_following,
  input  logic        is_last_customer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  route_number,
  output logic [8:0]  route_begin,
  output logic [8:0]  route_end,
  output logic [47:0] split_cost,
  output logic        no_solution,
  output logic        last_route
);
  import lfrs_pkg::*;

  typedef enum logic [16:0] {
    S_LOAD    = 17'h00001,
    S_CLR     = 17'h00002,
    S_KCHK    = 17'h00004,
    S_PRD     = 17'h00008,
    S_PCHK    = 17'h00010,
    S_JRD     = 17'h00020,
    S_JADD    = 17'h00040,
    S_JBACK   = 17'h00080,
    S_JMUL    = 17'h00100,
    S_JSUM    = 17'h00200,
    S_JCMP    = 17'h00400,
    S_SELRD   = 17'h00800,
    S_SELCHK  = 17'h01000,
    S_SCANRD  = 17'h02000,
    S_SCANCHK = 17'h04000,
    S_BTRD    = 17'h08000,
    S_BTEMIT  = 17'h10000
  } state_t;

  // Configuration registers
  logic [15:0] vehicle_capacity;
  logic [23:0] duration_limit;
  logic [19:0] capacity_penalty;
  logic [19:0] duration_penalty;
  logic        duration_check_on;
  logic [4:0]  fleet_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_capacity  <= 16'hFFFF;
      duration_limit    <= 24'hFFFFFF;
      capacity_penalty  <= 20'd256;
      duration_penalty  <= 20'd256;
      duration_check_on <= 1'b0;
      fleet_size        <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY:  vehicle_capacity  <= cfg_data[15:0];
        CFG_DUR_LIMIT: duration_limit    <= cfg_data;
        CFG_CAP_PEN:   capacity_penalty  <= cfg_data[19:0];
        CFG_DUR_PEN:   duration_penalty  <= cfg_data[19:0];
        CFG_DUR_ON:    duration_check_on <= cfg_data[0];
        CFG_FLEET:     fleet_size        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Effective fleet: zero acts as one, clamp to MAX_ROUTES
  logic [ROUTE_W-1:0] fleet_eff;
  always_comb begin
    if (fleet_size == 5'd0) begin
      fleet_eff = ROUTE_W'(1);
    end else if (32'(fleet_size) > MAX_ROUTES) begin
      fleet_eff = ROUTE_W'(MAX_ROUTES);
    end else begin
      fleet_eff = ROUTE_W'(fleet_size);
    end
  end

  state_t state;

  // Customer record stores
  logic [15:0] dem_mem [MAX_CUSTOMERS];
  logic [23:0] srv_mem [MAX_CUSTOMERS];
  logic [23:0] fdp_mem [MAX_CUSTOMERS];
  logic [23:0] tdp_mem [MAX_CUSTOMERS];
  logic [23:0] tfl_mem [MAX_CUSTOMERS];
  logic [15:0] rd_dem;
  logic [23:0] rd_srv;
  logic [23:0] rd_fdp;
  logic [23:0] rd_tdp;
  logic [23:0] rd_tfl;

  logic [POS_W-1:0] count;
  logic [POS_W-1:0] n_cust;
  logic [POS_W-1:0] i_pos;
  logic [POS_W-1:0] j_pos;
  logic [POS_W-1:0] c_pos;
  logic [POS_W-1:0] end_pos;
  logic [POS_W-1:0] ci;
  logic [ROUTE_W-1:0] k_row;
  logic [ROUTE_W-1:0] m_routes;
  logic [ROUTE_W-1:0] routes;
  logic [TAB_AW-1:0] base_k;
  logic [TAB_AW-1:0] base_k1;
  logic [TAB_AW-1:0] sbase;
  logic [TAB_AW-1:0] rbase;

  logic in_acc;
  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_acc && 32'(count) < MAX_CUSTOMERS) begin
      dem_mem[count[STORE_AW-1:0]] <= demand;
      srv_mem[count[STORE_AW-1:0]] <= service_time;
      fdp_mem[count[STORE_AW-1:0]] <= from_depot;
      tdp_mem[count[STORE_AW-1:0]] <= to_depot;
      tfl_mem[count[STORE_AW-1:0]] <= to_following;
    end
  end

  // Record c = j-1 and the leg from record c-1
  logic [POS_W-1:0] c_prev;
  assign c_pos  = j_pos - POS_W'(1);
  assign c_prev = j_pos - POS_W'(2);

  always_ff @(posedge clk) begin
    rd_dem <= dem_mem[c_pos[STORE_AW-1:0]];
    rd_srv <= srv_mem[c_pos[STORE_AW-1:0]];
    rd_fdp <= fdp_mem[c_pos[STORE_AW-1:0]];
    rd_tdp <= tdp_mem[c_pos[STORE_AW-1:0]];
    rd_tfl <= tfl_mem[c_prev[STORE_AW-1:0]];
  end

  // Path cost and predecessor tables
  logic [COST_W-1:0] cost_mem [TAB_DEPTH];
  logic [POS_W-1:0]  pred_mem [TAB_DEPTH];
  logic [TAB_AW-1:0] tab_addr;
  logic              tab_we;
  logic [COST_W-1:0] tab_wcost;
  logic [POS_W-1:0]  tab_wpred;
  logic [COST_W-1:0] rd_cost;
  logic [POS_W-1:0]  rd_pred;

  always_ff @(posedge clk) begin
    if (tab_we) begin
      cost_mem[tab_addr] <= tab_wcost;
      pred_mem[tab_addr] <= tab_wpred;
    end
    rd_cost <= cost_mem[tab_addr];
    rd_pred <= pred_mem[tab_addr];
  end

  // Shared route-cost unit
  cost_cmd_t         cmd;
  cost_cfg_t         ccfg;
  logic [23:0]       leg;
  logic [COST_W-1:0] route_cost;
  logic              cut;

  assign ccfg = '{capacity: vehicle_capacity, dur_limit: duration_limit,
                  cap_pen: capacity_penalty, dur_pen: duration_penalty,
                  dur_on: duration_check_on};
  assign leg  = (j_pos == i_pos + POS_W'(1)) ? rd_fdp : rd_tfl;

  lfrs_cost_unit u_cost (
    .clk          (clk),
    .cmd          (cmd),
    .cfg          (ccfg),
    .demand       (rd_dem),
    .service_time (rd_srv),
    .leg          (leg),
    .to_depot     (rd_tdp),
    .route_cost   (route_cost),
    .cut          (cut)
  );

  logic [COST_W-1:0] p_cost;
  logic [COST_W-1:0] cur_cost;
  logic [COST_W-1:0] best;
  logic [COST_W:0]   tot_raw;
  logic [COST_W-1:0] tot;
  logic              out_free;
  logic              out_load;

  assign tot_raw  = {1'b0, p_cost} + {1'b0, route_cost};
  assign tot      = (tot_raw > (COST_W + 1)'(COST_SAT)) ? COST_SAT : tot_raw[COST_W-1:0];
  assign out_free = !out_valid || !out_stall;
  // A new result word goes into the output register this cycle
  assign out_load = out_free && ((state == S_SELCHK && rd_cost == COST_UNREACH) ||
                                 state == S_BTEMIT);

  always_comb begin
    cmd.clr  = (state == S_PCHK);
    cmd.add  = (state == S_JADD);
    cmd.back = (state == S_JBACK);
    cmd.mul  = (state == S_JMUL);
    cmd.sum  = (state == S_JSUM);
    tab_we    = 1'b0;
    tab_wcost = COST_UNREACH;
    tab_wpred = '0;
    case (state)
      S_CLR: begin
        tab_addr = base_k + TAB_AW'(ci);
        tab_we   = 1'b1;
        if (base_k == '0 && ci == '0) begin
          tab_wcost = '0;
        end
      end
      S_PRD, S_PCHK: tab_addr = base_k + TAB_AW'(i_pos);
      S_JCMP: begin
        tab_addr  = base_k1 + TAB_AW'(j_pos);
        tab_we    = (tot < cur_cost);
        tab_wcost = tot;
        tab_wpred = i_pos;
      end
      S_SELRD, S_SELCHK, S_SCANRD, S_SCANCHK: tab_addr = sbase + TAB_AW'(n_cust);
      S_BTRD, S_BTEMIT: tab_addr = sbase + TAB_AW'(end_pos);
      default: tab_addr = base_k1 + TAB_AW'(j_pos);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (is_last_customer) begin
              n_cust   <= (32'(count) < MAX_CUSTOMERS) ? count + POS_W'(1) : count;
              count    <= '0;
              m_routes <= fleet_eff;
              base_k   <= '0;
              k_row    <= '0;
              ci       <= '0;
              state    <= S_CLR;
            end else if (32'(count) < MAX_CUSTOMERS) begin
              count <= count + POS_W'(1);
            end
          end
        end
        // Sweep rows 0..m, positions 0..n
        S_CLR: begin
          if (ci == n_cust) begin
            ci <= '0;
            if (k_row == m_routes) begin
              base_k  <= '0;
              base_k1 <= TAB_AW'(ROW_LEN);
              k_row   <= '0;
              i_pos   <= '0;
              state   <= S_KCHK;
            end else begin
              k_row  <= k_row + ROUTE_W'(1);
              base_k <= base_k + TAB_AW'(ROW_LEN);
            end
          end else begin
            ci <= ci + POS_W'(1);
          end
        end
        S_KCHK: begin
          if (k_row == m_routes) begin
            sbase <= base_k;
            state <= S_SELRD;
          end else if (i_pos < n_cust) begin
            state <= S_PRD;
          end else begin
            k_row   <= k_row + ROUTE_W'(1);
            i_pos   <= i_pos + POS_W'(1);
            base_k  <= base_k1;
            base_k1 <= base_k1 + TAB_AW'(ROW_LEN);
          end
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (rd_cost == COST_UNREACH) begin
            if (i_pos + POS_W'(1) < n_cust) begin
              i_pos <= i_pos + POS_W'(1);
              state <= S_PRD;
            end else begin
              k_row   <= k_row + ROUTE_W'(1);
              i_pos   <= POS_W'(k_row) + POS_W'(1);
              base_k  <= base_k1;
              base_k1 <= base_k1 + TAB_AW'(ROW_LEN);
              state   <= S_KCHK;
            end
          end else begin
            p_cost <= rd_cost;
            j_pos  <= i_pos + POS_W'(1);
            state  <= S_JRD;
          end
        end
        // Drop the start once the load cutoff trips
        S_JRD: begin
          if (cut) begin
            if (i_pos + POS_W'(1) < n_cust) begin
              i_pos <= i_pos + POS_W'(1);
              state <= S_PRD;
            end else begin
              k_row   <= k_row + ROUTE_W'(1);
              i_pos   <= POS_W'(k_row) + POS_W'(1);
              base_k  <= base_k1;
              base_k1 <= base_k1 + TAB_AW'(ROW_LEN);
              state   <= S_KCHK;
            end
          end else begin
            state <= S_JADD;
          end
        end
        S_JADD: begin
          cur_cost <= rd_cost;
          state    <= S_JBACK;
        end
        S_JBACK: state <= S_JMUL;
        S_JMUL:  state <= S_JSUM;
        S_JSUM:  state <= S_JCMP;
        S_JCMP: begin
          if (j_pos == n_cust) begin
            if (i_pos + POS_W'(1) < n_cust) begin
              i_pos <= i_pos + POS_W'(1);
              state <= S_PRD;
            end else begin
              k_row   <= k_row + ROUTE_W'(1);
              i_pos   <= POS_W'(k_row) + POS_W'(1);
              base_k  <= base_k1;
              base_k1 <= base_k1 + TAB_AW'(ROW_LEN);
              state   <= S_KCHK;
            end
          end else begin
            j_pos <= j_pos + POS_W'(1);
            state <= S_JRD;
          end
        end
        S_SELRD: state <= S_SELCHK;
        S_SELCHK: begin
          best   <= rd_cost;
          routes <= m_routes;
          rbase  <= sbase;
          if (rd_cost == COST_UNREACH) begin
            if (out_free) begin
              out_valid    <= 1'b1;
              route_number <= '0;
              route_begin  <= '0;
              route_end    <= '0;
              split_cost   <= '0;
              no_solution  <= 1'b1;
              last_route   <= 1'b1;
              state        <= S_LOAD;
            end
          end else begin
            k_row <= ROUTE_W'(1);
            sbase <= TAB_AW'(ROW_LEN);
            state <= (m_routes == ROUTE_W'(1)) ? S_BTRD : S_SCANRD;
            if (m_routes == ROUTE_W'(1)) begin
              end_pos <= n_cust;
            end
          end
        end
        S_SCANRD: state <= S_SCANCHK;
        // Strictly lower wins, so ties keep the earlier choice
        S_SCANCHK: begin
          if (rd_cost < best) begin
            best   <= rd_cost;
            routes <= k_row;
            rbase  <= sbase;
          end
          if (k_row + ROUTE_W'(1) == m_routes) begin
            state   <= S_BTRD;
            end_pos <= n_cust;
          end else begin
            k_row <= k_row + ROUTE_W'(1);
            sbase <= sbase + TAB_AW'(ROW_LEN);
            state <= S_SCANRD;
          end
        end
        // Walk predecessors back from the end of the tour
        S_BTRD: begin
          if (end_pos == n_cust && k_row != routes) begin
            k_row <= routes;
            sbase <= rbase;
          end else begin
            state <= S_BTEMIT;
          end
        end
        S_BTEMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            route_number <= 4'(k_row - ROUTE_W'(1));
            route_begin  <= 9'(rd_pred);
            route_end    <= 9'(end_pos);
            split_cost   <= best;
            no_solution  <= 1'b0;
            last_route   <= (k_row == ROUTE_W'(1));
            end_pos      <= rd_pred;
            k_row        <= k_row - ROUTE_W'(1);
            sbase        <= sbase - TAB_AW'(ROW_LEN);
            state        <= (k_row == ROUTE_W'(1)) ? S_LOAD : S_BTRD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
